@@ src/emmc_pkg.sv @@
`timescale 1ns / 1ps

package emmc_pkg;

   localparam int TIMER_W = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX = 17'h1FFFF;

   // map codes
   localparam logic [1:0] MAP_NORMAL = 2'd0;
   localparam logic [1:0] MAP_RACE = 2'd1;
   localparam logic [1:0] MAP_EMERGENCY = 2'd2;

   // rpm status codes
   localparam logic [1:0] RPM_OVERSPEED = 2'd1;
   localparam logic [1:0] RPM_BAD_SIGNAL = 2'd2;

   // button command codes
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_CHANGE_SCREEN = 2'd1;
   localparam logic [1:0] CMD_CHANGE_BRIGHTNESS = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MAP_COOLDOWN = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMITER_HOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_PRESS = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BUTTON_COOLDOWN = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_STOICH_AFR = 3'd4;

   // register reset values; stoichiometric AFR 14.7 in hundredths
   localparam logic [15:0] MAP_COOLDOWN_RESET = 16'd1000;
   localparam logic [15:0] LIMITER_HOLD_RESET = 16'd2000;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [15:0] BUTTON_COOLDOWN_RESET = 16'd500;
   localparam logic [11:0] STOICH_AFR_RESET = 12'd1470;

   typedef struct packed {
      logic [15:0] elapsed_ms;
      logic        map_switch_high;
      logic        control_button_high;
      logic        engine_oil_danger;
      logic        gearbox_oil_danger;
      logic [1:0]  rpm_status;
      logic        engine_running;
      logic        afr_sensor_cold;
      logic [11:0] afr_x100;
      logic        take_command;
   } req_payload_type;

   typedef struct packed {
      logic        map_select_pin;
      logic        lambda_lean_pin;
      logic        gauge_power_pin;
      logic [1:0]  reported_map;
      logic        limiter_active;
      logic [1:0]  pending_command;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] map_cooldown_ms;
      logic [15:0] limiter_hold_ms;
      logic [15:0] long_press_ms;
      logic [15:0] button_cooldown_ms;
      logic [11:0] stoich_afr_x100;
   } config_type;

   typedef struct packed {
      logic        map_select;
      logic [1:0]  reported_map;
      logic        limiter_active;
   } map_status_type;

   function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] t,
                                                 input logic [15:0] d);
      logic [TIMER_W:0] s;
      s = {1'b0, t} + {2'b00, d};
      return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
   endfunction

endpackage

@@ src/emmc_if.sv @@
`timescale 1ns / 1ps

interface emmc_req_if;
   logic                     valid;
   logic                     ready;
   emmc_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface emmc_rsp_if;
   logic                     valid;
   logic                     ready;
   emmc_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface emmc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [emmc_pkg::CSR_ADDR_W-1:0]   addr;
   logic [emmc_pkg::CSR_DATA_W-1:0]   wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink (input valid, input addr, input wdata, output ready);
endinterface

@@ src/emmc_map_ctrl.sv @@
`timescale 1ns / 1ps

module emmc_map_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  emmc_pkg::req_payload_type req,
   input  emmc_pkg::config_type      cfg,
   output emmc_pkg::map_status_type  status
);
   import emmc_pkg::*;

   logic [1:0]         map_ff, map_in;
   logic               cool_on_ff, cool_on_in;
   logic [TIMER_W-1:0] cool_tmr_ff, cool_tmr_in;
   logic               lim_ff, lim_in;
   logic [1:0]         next_map;
   logic [15:0]        limit;

   always_comb begin
      next_map = map_ff;
      cool_on_in = cool_on_ff;
      cool_tmr_in = cool_tmr_ff;
      lim_in = lim_ff;
      limit = lim_ff ? cfg.limiter_hold_ms : cfg.map_cooldown_ms;
      if (!cool_on_ff) begin
         next_map = req.map_switch_high ? MAP_RACE : MAP_NORMAL;
      end else if (cool_tmr_ff >= {1'b0, limit}) begin
         // expiring tick: timer is not advanced
         cool_tmr_in = '0;
         cool_on_in = 1'b0;
         lim_in = 1'b0;
      end else begin
         cool_tmr_in = sat_add(cool_tmr_ff, req.elapsed_ms);
      end
      if (req.engine_oil_danger || req.gearbox_oil_danger) begin
         next_map = MAP_NORMAL;
      end
      if (req.rpm_status == RPM_OVERSPEED) begin
         next_map = MAP_NORMAL;
         lim_in = 1'b1;
      end
      if (req.rpm_status == RPM_BAD_SIGNAL) begin
         next_map = MAP_EMERGENCY;
      end
      map_in = next_map;
      if (next_map != map_ff) begin
         cool_on_in = 1'b1;
      end
   end

   always_comb begin
      status.map_select = (map_in == MAP_RACE);
      status.reported_map = lim_in ? MAP_RACE : map_in;
      status.limiter_active = lim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= MAP_NORMAL;
         cool_on_ff <= 1'b0;
         cool_tmr_ff <= '0;
         lim_ff <= 1'b0;
      end else if (en) begin
         map_ff <= map_in;
         cool_on_ff <= cool_on_in;
         cool_tmr_ff <= cool_tmr_in;
         lim_ff <= lim_in;
      end
   end

   a_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !cool_on_ff |-> cool_tmr_ff == '0)
      else $error("map cooldown timer running while cooldown is off");

   a_map_code: assert property (@(posedge clock) disable iff (reset)
      map_ff <= MAP_EMERGENCY)
      else $error("map state holds an unused code");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(map_ff) && $stable(cool_tmr_ff))
      else $error("map state changed without an item");

endmodule

@@ src/emmc_button.sv @@
`timescale 1ns / 1ps

module emmc_button (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  emmc_pkg::req_payload_type req,
   input  emmc_pkg::config_type      cfg,
   output logic [1:0]                pending_command
);
   import emmc_pkg::*;

   logic [TIMER_W-1:0] press_ff, press_in;
   logic               bc_on_ff, bc_on_in;
   logic [TIMER_W-1:0] bc_tmr_ff, bc_tmr_in;
   logic [1:0]         cmd_ff, cmd_in;
   logic [1:0]         cmd_now;

   always_comb begin
      press_in = press_ff;
      bc_on_in = bc_on_ff;
      bc_tmr_in = bc_tmr_ff;
      cmd_now = cmd_ff;
      if (!bc_on_ff) begin
         if (req.control_button_high) begin
            if (press_ff >= {1'b0, cfg.long_press_ms}) begin
               cmd_now = CMD_CHANGE_SCREEN;
               press_in = '0;
               bc_on_in = 1'b1;
            end else begin
               press_in = sat_add(press_ff, req.elapsed_ms);
            end
         end else begin
            // release after a short hold
            if (press_ff != '0) begin
               cmd_now = CMD_CHANGE_BRIGHTNESS;
            end
            press_in = '0;
         end
      end else if (bc_tmr_ff >= {1'b0, cfg.button_cooldown_ms}) begin
         bc_on_in = 1'b0;
         bc_tmr_in = '0;
      end else begin
         bc_tmr_in = sat_add(bc_tmr_ff, req.elapsed_ms);
      end
      // report first, then read-and-clear
      cmd_in = req.take_command ? CMD_NONE : cmd_now;
   end

   assign pending_command = cmd_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= '0;
         bc_on_ff <= 1'b0;
         bc_tmr_ff <= '0;
         cmd_ff <= CMD_NONE;
      end else if (en) begin
         press_ff <= press_in;
         bc_on_ff <= bc_on_in;
         bc_tmr_ff <= bc_tmr_in;
         cmd_ff <= cmd_in;
      end
   end

   a_cooldown_no_press: assert property (@(posedge clock) disable iff (reset)
      bc_on_ff |-> press_ff == '0)
      else $error("press timer running during button cooldown");

   a_cooldown_timer_idle: assert property (@(posedge clock) disable iff (reset)
      !bc_on_ff |-> bc_tmr_ff == '0)
      else $error("button cooldown timer running while cooldown is off");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      en && req.take_command |=> cmd_ff == CMD_NONE)
      else $error("taken command still held");

endmodule

@@ src/engine_map_mode_controller.sv @@
`timescale 1ns / 1ps

// A beat accepted on req_chan is loaded into the input register, and its result then
// into the result register, which is presented on rsp_chan.
// Throughput: one beat per cycle; the input stage advances whenever the result
// register is empty or being taken, so a held result stalls at most one beat.
// Reset (synchronous, active high) clears the control state, restores register defaults
// and empties both stages.
module engine_map_mode_controller (
   input  logic clock,
   input  logic reset,
   emmc_req_if.sink   req_chan,
   emmc_rsp_if.source rsp_chan,
   emmc_csr_if.sink   csr_chan
);
   import emmc_pkg::*;

   config_type      cfg_ff;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            advance;
   logic            lean_ff, lean_in;
   logic            gauge_ff;
   map_status_type  map_status;
   logic [1:0]      pending_command;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_cooldown_ms <= MAP_COOLDOWN_RESET;
         cfg_ff.limiter_hold_ms <= LIMITER_HOLD_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
         cfg_ff.button_cooldown_ms <= BUTTON_COOLDOWN_RESET;
         cfg_ff.stoich_afr_x100 <= STOICH_AFR_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.addr)
            REG_MAP_COOLDOWN: cfg_ff.map_cooldown_ms <= csr_chan.wdata;
            REG_LIMITER_HOLD: cfg_ff.limiter_hold_ms <= csr_chan.wdata;
            REG_LONG_PRESS: cfg_ff.long_press_ms <= csr_chan.wdata;
            REG_BUTTON_COOLDOWN: cfg_ff.button_cooldown_ms <= csr_chan.wdata;
            REG_STOICH_AFR: cfg_ff.stoich_afr_x100 <= csr_chan.wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.payload;
      end
   end

   emmc_map_ctrl u_map (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .req    (in_data_ff),
      .cfg    (cfg_ff),
      .status (map_status)
   );

   emmc_button u_button (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .req             (in_data_ff),
      .cfg             (cfg_ff),
      .pending_command (pending_command)
   );

   // lambda emulation holds while the sensor is cold or AFR sits at stoich
   always_comb begin
      lean_in = lean_ff;
      if (!in_data_ff.afr_sensor_cold) begin
         if (in_data_ff.afr_x100 > cfg_ff.stoich_afr_x100) begin
            lean_in = 1'b1;
         end else if (in_data_ff.afr_x100 < cfg_ff.stoich_afr_x100) begin
            lean_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_data_in.map_select_pin = map_status.map_select;
      rsp_data_in.lambda_lean_pin = lean_in;
      rsp_data_in.gauge_power_pin = !in_data_ff.engine_running;
      rsp_data_in.reported_map = map_status.reported_map;
      rsp_data_in.limiter_active = map_status.limiter_active;
      rsp_data_in.pending_command = pending_command;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lean_ff <= 1'b0;
         gauge_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            lean_ff <= lean_in;
            gauge_ff <= in_data_ff.engine_running;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_limiter_reports_race: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.limiter_active |-> rsp_data_ff.reported_map == MAP_RACE)
      else $error("limiter active but reported map is not race");

   a_gauge_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.gauge_power_pin == !gauge_ff)
      else $error("gauge pin disagrees with gauge state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_valid_ff && !rsp_chan.ready))
      else $error("result register overwritten while stalled");

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input beat dropped");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

@@ test/engine_map_mode_controller_test.sv @@
`timescale 1ns / 1ps

module engine_map_mode_controller_test;
   import emmc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_COUNT = 8;
   localparam int TICKS_PER_HALF = 118;
   localparam int REG_COUNT = 5;
   localparam int SHOW_LIMIT = 10;
   localparam logic [1:0] RPM_NORMAL = 2'd0;
   localparam logic [1:0] RPM_UNUSED = 2'd3;

   logic clock;
   logic reset;

   emmc_req_if req_chan ();
   emmc_rsp_if rsp_chan ();
   emmc_csr_if csr_chan ();

   engine_map_mode_controller dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // controller shadow state
   logic [1:0]  ctl_map;
   logic        map_cool_on;
   logic [16:0] map_timer;
   logic        limiter_on;
   logic        gauge_on;
   logic        lean;
   logic [16:0] press_timer;
   logic        btn_cool_on;
   logic [16:0] btn_timer;
   logic [1:0]  cmd_held;

   // register shadow
   logic [15:0] cfg_map_cool;
   logic [15:0] cfg_hold;
   logic [15:0] cfg_long;
   logic [15:0] cfg_btn_cool;
   logic [11:0] cfg_stoich;

   req_payload_type pending_ticks[$];
   rsp_payload_type expected_status[$];
   logic [CSR_ADDR_W-1:0] csr_addr_q[$];
   logic [CSR_DATA_W-1:0] csr_data_q[$];

   int sender_idle_pct;
   int recv_stall_pct;
   int mismatch_count = 0;
   int cycle_count = 0;
   int settle;
   logic sw_level;
   logic btn_level;
   logic run_level;
   rsp_payload_type want;
   rsp_payload_type got;

   function automatic logic [16:0] clamp_add(input logic [16:0] acc, input logic [15:0] inc);
      logic [17:0] total;
      total = acc + inc;
      if (total > 18'd131071)
         return 17'd131071;
      return total[16:0];
   endfunction

   function automatic rsp_payload_type advance_controller(input req_payload_type t);
      rsp_payload_type r;
      logic [1:0] next_map;
      logic [15:0] limit;
      next_map = ctl_map;
      if (!map_cool_on) begin
         next_map = t.map_switch_high ? MAP_RACE : MAP_NORMAL;
      end else begin
         limit = limiter_on ? cfg_hold : cfg_map_cool;
         if (map_timer >= {1'b0, limit}) begin
            map_timer = '0;
            map_cool_on = 1'b0;
            limiter_on = 1'b0;
         end else begin
            map_timer = clamp_add(map_timer, t.elapsed_ms);
         end
      end
      if (t.engine_oil_danger || t.gearbox_oil_danger)
         next_map = MAP_NORMAL;
      if (t.rpm_status == RPM_OVERSPEED) begin
         next_map = MAP_NORMAL;
         limiter_on = 1'b1;
      end
      if (t.rpm_status == RPM_BAD_SIGNAL)
         next_map = MAP_EMERGENCY;
      if (next_map != ctl_map) begin
         ctl_map = next_map;
         map_cool_on = 1'b1;
      end

      gauge_on = t.engine_running;

      // equal AFR keeps the previous lambda level
      if (!t.afr_sensor_cold) begin
         if (t.afr_x100 > cfg_stoich)
            lean = 1'b1;
         else if (t.afr_x100 < cfg_stoich)
            lean = 1'b0;
      end

      if (!btn_cool_on) begin
         if (t.control_button_high) begin
            if (press_timer >= {1'b0, cfg_long}) begin
               cmd_held = CMD_CHANGE_SCREEN;
               press_timer = '0;
               btn_cool_on = 1'b1;
            end else begin
               press_timer = clamp_add(press_timer, t.elapsed_ms);
            end
         end else begin
            if (press_timer != '0)
               cmd_held = CMD_CHANGE_BRIGHTNESS;
            press_timer = '0;
         end
      end else begin
         if (btn_timer >= {1'b0, cfg_btn_cool}) begin
            btn_cool_on = 1'b0;
            btn_timer = '0;
         end else begin
            btn_timer = clamp_add(btn_timer, t.elapsed_ms);
         end
      end

      r.map_select_pin = (ctl_map == MAP_RACE);
      r.lambda_lean_pin = lean;
      r.gauge_power_pin = !gauge_on;
      r.reported_map = limiter_on ? MAP_RACE : ctl_map;
      r.limiter_active = limiter_on;
      r.pending_command = cmd_held;
      if (t.take_command)
         cmd_held = CMD_NONE;
      return r;
   endfunction

   function automatic req_payload_type make_tick(input int ms, input logic sw, input logic btn,
                                                 input logic eng, input logic gbx,
                                                 input logic [1:0] rpm, input logic run,
                                                 input logic cold, input int afr,
                                                 input logic take);
      req_payload_type t;
      t.elapsed_ms = 16'(ms);
      t.map_switch_high = sw;
      t.control_button_high = btn;
      t.engine_oil_danger = eng;
      t.gearbox_oil_danger = gbx;
      t.rpm_status = rpm;
      t.engine_running = run;
      t.afr_sensor_cold = cold;
      t.afr_x100 = 12'(afr);
      t.take_command = take;
      return t;
   endfunction

   // mostly held switch/button levels so presses and cooldowns play out; some pure noise
   function automatic req_payload_type random_tick();
      req_payload_type t;
      int r;
      int afr;
      logic [1:0] rpm;
      if ($urandom_range(99) < 10) begin
         t = make_tick(int'($urandom_range(65535)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 2'($urandom_range(3)),
                       1'($urandom_range(1)), 1'($urandom_range(1)),
                       int'($urandom_range(4095)), 1'($urandom_range(1)));
         return t;
      end
      if ($urandom_range(9) == 0)
         sw_level = !sw_level;
      if ($urandom_range(5) == 0)
         btn_level = !btn_level;
      if ($urandom_range(19) == 0)
         run_level = !run_level;
      r = $urandom_range(99);
      if (r < 50)
         t.elapsed_ms = 16'($urandom_range(200));
      else if (r < 80)
         t.elapsed_ms = 16'($urandom_range(1500));
      else if (r < 92)
         t.elapsed_ms = 16'($urandom_range(65535));
      else if (r < 96)
         t.elapsed_ms = 16'hFFFF;
      else
         t.elapsed_ms = '0;
      r = $urandom_range(99);
      if (r < 86)
         rpm = RPM_NORMAL;
      else if (r < 93)
         rpm = RPM_OVERSPEED;
      else if (r < 97)
         rpm = RPM_BAD_SIGNAL;
      else
         rpm = RPM_UNUSED;
      if ($urandom_range(99) < 70) begin
         afr = int'(cfg_stoich) + int'($urandom_range(120)) - 60;
         if (afr < 0)
            afr = 0;
         if (afr > 4095)
            afr = 4095;
      end else begin
         afr = int'($urandom_range(4095));
      end
      t.map_switch_high = sw_level;
      t.control_button_high = btn_level;
      t.engine_oil_danger = ($urandom_range(99) < 4);
      t.gearbox_oil_danger = ($urandom_range(99) < 4);
      t.rpm_status = rpm;
      t.engine_running = run_level;
      t.afr_sensor_cold = ($urandom_range(99) < 20);
      t.afr_x100 = 12'(afr);
      t.take_command = ($urandom_range(99) < 35);
      return t;
   endfunction

   task automatic queue_write(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_addr_q.push_back(idx);
      csr_data_q.push_back(data);
   endtask

   task automatic queue_all_regs(input logic [15:0] cool, input logic [15:0] hold,
                                 input logic [15:0] long_ms, input logic [15:0] btn_cool,
                                 input logic [15:0] stoich);
      queue_write(REG_MAP_COOLDOWN, cool);
      queue_write(REG_LIMITER_HOLD, hold);
      queue_write(REG_LONG_PRESS, long_ms);
      queue_write(REG_BUTTON_COOLDOWN, btn_cool);
      queue_write(REG_STOICH_AFR, stoich);
   endtask

   // must start on a clock edge; valid stays high across back-to-back writes
   task automatic flush_csr_writes();
      while (csr_addr_q.size() > 0) begin
         csr_chan.valid <= 1'b1;
         csr_chan.addr <= csr_addr_q.pop_front();
         csr_chan.wdata <= csr_data_q.pop_front();
         do @(posedge clock);
         while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_ticks.size() > 0 || req_chan.valid || expected_status.size() > 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_ticks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_chan.payload <= pending_ticks.pop_front();
            req_chan.valid <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: register writes, accepted ticks, status beats
   always @(posedge clock) begin
      if (reset) begin
         ctl_map = MAP_NORMAL;
         map_cool_on = 1'b0;
         map_timer = '0;
         limiter_on = 1'b0;
         gauge_on = 1'b0;
         lean = 1'b0;
         press_timer = '0;
         btn_cool_on = 1'b0;
         btn_timer = '0;
         cmd_held = CMD_NONE;
         cfg_map_cool = MAP_COOLDOWN_RESET;
         cfg_hold = LIMITER_HOLD_RESET;
         cfg_long = LONG_PRESS_RESET;
         cfg_btn_cool = BUTTON_COOLDOWN_RESET;
         cfg_stoich = STOICH_AFR_RESET;
         expected_status.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.addr)
               REG_MAP_COOLDOWN: cfg_map_cool = csr_chan.wdata;
               REG_LIMITER_HOLD: cfg_hold = csr_chan.wdata;
               REG_LONG_PRESS: cfg_long = csr_chan.wdata;
               REG_BUTTON_COOLDOWN: cfg_btn_cool = csr_chan.wdata;
               REG_STOICH_AFR: cfg_stoich = csr_chan.wdata[11:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            expected_status.push_back(advance_controller(req_chan.payload));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("unexpected status beat %h", got);
            end else begin
               want = expected_status.pop_front();
               if (got.map_select_pin !== want.map_select_pin ||
                   got.lambda_lean_pin !== want.lambda_lean_pin ||
                   got.gauge_power_pin !== want.gauge_power_pin ||
                   got.reported_map !== want.reported_map ||
                   got.limiter_active !== want.limiter_active ||
                   got.pending_command !== want.pending_command) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_LIMIT) begin
                     $display("status mismatch (exp/got): sel %b/%b lean %b/%b gauge %b/%b",
                              want.map_select_pin, got.map_select_pin,
                              want.lambda_lean_pin, got.lambda_lean_pin,
                              want.gauge_power_pin, got.gauge_power_pin);
                     $display("   map %0d/%0d lim %b/%b cmd %0d/%0d",
                              want.reported_map, got.reported_map,
                              want.limiter_active, got.limiter_active,
                              want.pending_command, got.pending_command);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.addr = '0;
      csr_chan.wdata = '0;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      sw_level = 1'b0;
      btn_level = 1'b0;
      run_level = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed ticks under default registers
      pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, RPM_NORMAL, 0, 0, 0, 0));
      pending_ticks.push_back(make_tick(10, 1, 0, 0, 0, RPM_NORMAL, 1, 0, 2500, 0));
      pending_ticks.push_back(make_tick(65535, 0, 0, 0, 0, RPM_NORMAL, 1, 0, 0, 0));
      // cooldown expires; equal AFR holds lambda
      pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(5, 0, 0, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(1000, 1, 0, 1, 0, RPM_NORMAL, 1, 0, 1500, 0));
      pending_ticks.push_back(make_tick(0, 1, 0, 0, 1, RPM_NORMAL, 0, 0, 1400, 0));
      // overspeed without a map change arms the limiter
      pending_ticks.push_back(make_tick(10, 1, 0, 0, 0, RPM_OVERSPEED, 1, 0, 1400, 0));
      pending_ticks.push_back(make_tick(10, 1, 0, 0, 0, RPM_BAD_SIGNAL, 1, 0, 1400, 0));
      pending_ticks.push_back(make_tick(2000, 1, 0, 0, 0, RPM_UNUSED, 1, 0, 1400, 0));
      pending_ticks.push_back(make_tick(0, 1, 0, 0, 0, RPM_UNUSED, 1, 1, 4095, 0));
      pending_ticks.push_back(make_tick(0, 1, 0, 0, 0, RPM_NORMAL, 1, 0, 4095, 0));
      // long press, then its cooldown
      pending_ticks.push_back(make_tick(600, 1, 1, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(600, 1, 1, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(0, 1, 1, 0, 0, RPM_NORMAL, 1, 0, 1470, 1));
      pending_ticks.push_back(make_tick(65535, 1, 0, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(0, 1, 1, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      // short press
      pending_ticks.push_back(make_tick(5, 1, 1, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(0, 1, 0, 0, 0, RPM_NORMAL, 1, 0, 1470, 0));
      pending_ticks.push_back(make_tick(0, 1, 0, 0, 0, RPM_NORMAL, 1, 0, 1470, 1));
      pending_ticks.push_back(make_tick(65535, 1, 1, 1, 1, RPM_UNUSED, 1, 1, 4095, 1));
      pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, RPM_NORMAL, 0, 0, 0, 1));
      wait_for_drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin sender_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         case (phase)
            0: queue_all_regs(100, 300, 150, 80, 1470);
            1: queue_all_regs(0, 0, 0, 0, 0);
            2: queue_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: queue_all_regs(250, 600, 400, 200, 2500);
            5: begin
               queue_all_regs(1000, 2000, 1000, 500, 1470);
               // unmapped indexes must be ignored
               for (int k = REG_COUNT; k < 8; k++)
                  queue_write(3'(k), 16'($urandom_range(65535)));
            end
            6: queue_all_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              16'($urandom_range(65535)));
            default: queue_all_regs(16'($urandom_range(1500)), 16'($urandom_range(1500)),
                                    16'($urandom_range(1500)), 16'($urandom_range(1500)),
                                    16'($urandom_range(65535)));
         endcase
         flush_csr_writes();
         repeat (2) @(posedge clock);
         // sender holds off mid-phase until every status beat is back
         for (int half = 0; half < 2; half++) begin
            repeat (TICKS_PER_HALF) pending_ticks.push_back(random_tick());
            wait_for_drain();
         end
      end

      settle = 0;
      while ((pending_ticks.size() > 0 || expected_status.size() > 0) && settle < 20000) begin
         @(posedge clock);
         settle++;
      end
      repeat (10) @(posedge clock);
      mismatch_count += expected_status.size();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
